// ===== hw/rtl/cst_pkg.sv =====
// Shared types, constants and the level test for the Collatz sieve residue test.
package cst_pkg;

	localparam int RES_W             = 32;
	localparam int STATE_W           = 52;
	localparam int LVL_W             = 6;
	localparam int MAX_DEPTH_DEF     = 32;
	localparam int SIEVE_DEPTH_RESET = 30;
	localparam int OUT_TDATA_W       = 8;

	typedef struct packed {
		logic [RES_W-1:0]   res;
		logic [STATE_W-1:0] n;
		logic [STATE_W-1:0] p;
		logic [STATE_W-1:0] q;
		logic               killed;
	} lane_t;

	// n = T^j(b), p = 3^c, q = 3^c * (b >> j); T^j(b mod 2^j) = n - q
	function automatic logic level_kills(
		input logic [STATE_W-1:0] n,
		input logic [STATE_W-1:0] p,
		input logic [STATE_W-1:0] q,
		input logic [RES_W-1:0]   b,
		input logic [LVL_W-1:0]   lvl,
		input logic [LVL_W-1:0]   depth
	);
		logic [STATE_W-1:0] lim;
		logic [STATE_W-1:0] d;
		logic [STATE_W-1:0] r;
		lim = STATE_W'(1) << lvl;
		d   = n - q;
		r   = STATE_W'(b) & (lim - STATE_W'(1));
		return (lvl != '0) && (lvl <= depth) && (p < lim) && (d <= r);
	endfunction

endpackage

// ===== hw/rtl/cst_cell.sv =====
// One sieve cell: one step of T, plus the kill test of the previous level.
module cst_cell #(
	parameter int LEVEL = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [cst_pkg::LVL_W-1:0] depth,
	input  logic                      valid_i,
	input  cst_pkg::lane_t            lane_i,
	output logic                      valid_o,
	output cst_pkg::lane_t            lane_o
);
	import cst_pkg::*;

	logic                odd;
	logic [STATE_W+1:0]  n3;
	logic [STATE_W-1:0]  t;
	logic [STATE_W-1:0]  t2;
	logic                kill;
	lane_t               nxt;
	logic                valid_s1;
	lane_t               lane_s1;

	always_comb begin
		odd  = lane_i.n[0];
		n3   = {2'b00, lane_i.n} + {1'b0, lane_i.n, 1'b0} + (STATE_W+2)'(1);
		t    = lane_i.q - (lane_i.res[LEVEL-1] ? lane_i.p : '0);
		t2   = t >> 1;
		kill = level_kills(lane_i.n, lane_i.p, lane_i.q, lane_i.res,
			LVL_W'(LEVEL-1), depth);
		nxt.res    = lane_i.res;
		nxt.n      = odd ? n3[STATE_W:1] : (lane_i.n >> 1);
		nxt.p      = odd ? (lane_i.p + (lane_i.p << 1)) : lane_i.p;
		nxt.q      = odd ? (t2 + (t2 << 1)) : t2;
		nxt.killed = lane_i.killed | kill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= nxt;
		end
	end

	assign valid_o = valid_s1;
	assign lane_o  = lane_s1;
endmodule

// ===== hw/rtl/cst_out.sv =====
// Last level test, output register and skid slot.
module cst_out #(
	parameter int MAX_DEPTH = cst_pkg::MAX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cst_pkg::LVL_W-1:0]       depth,
	input  logic                            valid_i,
	input  cst_pkg::lane_t                  lane_i,
	output logic                            full,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cst_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cst_pkg::*;

	logic live;
	logic in_v;
	logic out_valid_q;
	logic out_live_q;
	logic skid_valid_q;
	logic skid_live_q;

	always_comb begin
		live = !(lane_i.killed | level_kills(lane_i.n, lane_i.p, lane_i.q,
			lane_i.res, LVL_W'(MAX_DEPTH), depth));
		in_v = valid_i && !skid_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= in_v;
		end else if (in_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_live_q <= skid_live_q;
			end
		end else if (!out_valid_q || m_tready) begin
			out_live_q <= live;
		end else begin
			skid_live_q <= live;
		end
	end

	assign full     = skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_live_q};
endmodule

// ===== hw/rtl/collatz_sieve_residue_test_unit.sv =====
// Top level of the Collatz sieve residue test.
//
// Input stream s_*: one request per residue b in s_tdata. Output stream m_*:
// one result per request, in order, m_tdata[0] = live (b survives every
// sieve level up to the configured depth k).
// Config channel cfg_*: cfg_data sets k; 0 reads as 1, values above
// MAX_DEPTH read as MAX_DEPTH. Write only while no request is in flight.
// A row of MAX_DEPTH cells, one Collatz step each, carries every residue
// along with 3^c and the high-bit correction, so each level is tested with
// adds and compares only. One request per cycle is accepted while s_tready is
// high; requests pass the MAX_DEPTH cell registers, then the output register.
// The output register plus one skid slot decouple the sides: when the
// receiver stalls, the row keeps moving until the skid slot fills, then
// s_tready drops (a registered signal) and the whole row holds.
// Reset empties the row and sets k to 30 (clamped to MAX_DEPTH).
module collatz_sieve_residue_test_unit #(
	parameter int MAX_DEPTH = cst_pkg::MAX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cst_pkg::RES_W-1:0]       s_tdata,   // [31:0] residue
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cst_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] live, [7:1] zero
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cst_pkg::LVL_W-1:0]       cfg_data   // [5:0] sieve_depth
);
	import cst_pkg::*;

	localparam int DEPTH_RST = (SIEVE_DEPTH_RESET > MAX_DEPTH) ? MAX_DEPTH
		: SIEVE_DEPTH_RESET;

	logic [LVL_W-1:0] depth_q;
	logic             en;
	logic             full;
	logic             valids [0:MAX_DEPTH];
	lane_t            lanes  [0:MAX_DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= LVL_W'(DEPTH_RST);
		end else if (cfg_valid) begin
			if (cfg_data == '0) begin
				depth_q <= LVL_W'(1);
			end else if (cfg_data > LVL_W'(MAX_DEPTH)) begin
				depth_q <= LVL_W'(MAX_DEPTH);
			end else begin
				depth_q <= cfg_data;
			end
		end
	end

	assign en       = !full;
	assign s_tready = en;

	assign valids[0] = s_tvalid;
	assign lanes[0]  = '{
		res:    s_tdata,
		n:      STATE_W'(s_tdata),
		p:      STATE_W'(1),
		q:      STATE_W'(s_tdata),
		killed: 1'b0
	};

	for (genvar i = 1; i <= MAX_DEPTH; i++) begin : g_cell
		cst_cell #(
			.LEVEL(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.depth   (depth_q),
			.valid_i (valids[i-1]),
			.lane_i  (lanes[i-1]),
			.valid_o (valids[i]),
			.lane_o  (lanes[i])
		);
	end

	cst_out #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.depth    (depth_q),
		.valid_i  (valids[MAX_DEPTH]),
		.lane_i   (lanes[MAX_DEPTH]),
		.full     (full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);
endmodule

// ===== hw/rtl/cst_checker.sv =====
// Port-level checks for the sieve unit, bound to the top level.
module cst_checker #(
	parameter int MAX_DEPTH = cst_pkg::MAX_DEPTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cst_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cst_pkg::*;

	logic [LVL_W:0] pend_q;
	logic           in_acc;
	logic           out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (LVL_W+1)'(in_acc) - (LVL_W+1)'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != '0)
		else $error("result with no request in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= (LVL_W+1)'(MAX_DEPTH + 2))
		else $error("more requests in flight than stages");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:1] == '0)
		else $error("nonzero padding in result");
endmodule

bind collatz_sieve_residue_test_unit cst_checker #(
	.MAX_DEPTH(MAX_DEPTH)
) u_cst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

// ===== sim/collatz_sieve_residue_test_unit_tb.sv =====
// Self-checking testbench for the Collatz sieve residue test unit: streams residues, predicts live.
module collatz_sieve_residue_test_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cst_pkg::*;

	localparam int DEPTH_MAX = MAX_DEPTH_DEF;
	localparam int LATENCY   = DEPTH_MAX + 1;

	typedef struct {
		logic [RES_W-1:0] residue;
		int               depth;
		logic             live;
	} verdict_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [RES_W-1:0]       s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [LVL_W-1:0]       cfg_data;

	verdict_t     verdict_q[$];
	logic [LVL_W-1:0] depth_reg;
	int           mismatches;
	int           errors;
	int           n_sent;
	int           n_live;
	int           n_dead;
	int           n_in_stalls;
	int           n_depth_writes;
	int           hold_cycles;
	int           rx_gap;
	bit           rx_steady;
	bit           tx_steady;

	collatz_sieve_residue_test_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int active_depth(logic [LVL_W-1:0] d);
		if (d == '0)
			return 1;
		if (d > DEPTH_MAX)
			return DEPTH_MAX;
		return int'(d);
	endfunction

	// live = no level 1..k has 3^c < 2^j with T^j(b mod 2^j) <= b mod 2^j
	function automatic logic sieve_live(logic [RES_W-1:0] b, int k);
		logic [63:0] r;
		logic [63:0] n;
		logic [63:0] p3;
		for (int j = 1; j <= k; j++) begin
			r  = {32'd0, b} & ((64'd1 << j) - 64'd1);
			n  = r;
			p3 = 64'd1;
			for (int s = 0; s < j; s++) begin
				if (n[0]) begin
					n  = (64'd3 * n + 64'd1) >> 1;
					p3 = p3 * 64'd3;
				end else begin
					n = n >> 1;
				end
			end
			if (p3 < (64'd1 << j) && n <= r)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int rand_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// biased toward residues that get past the shallow levels
	function automatic logic [RES_W-1:0] pick_residue();
		logic [RES_W-1:0] v;
		logic [63:0]      ones;
		v = $urandom();
		case ($urandom_range(0, 4))
			0: ;
			1: v[1:0] = 2'b11;
			2: begin
				ones = (64'd1 << $urandom_range(2, 24)) - 64'd1;
				v    = v | ones[RES_W-1:0];
			end
			3: v = v >> $urandom_range(0, 31);
			default: v[2:0] = 3'b111;
		endcase
		return v;
	endfunction

	task automatic send_residue(input logic [RES_W-1:0] b, input int gap);
		verdict_t v;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		v.residue = b;
		v.depth   = active_depth(depth_reg);
		v.live    = sieve_live(b, v.depth);
		verdict_q.push_back(v);
		n_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_depth(input logic [LVL_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		depth_reg = d;
		n_depth_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_depth();
		logic [RES_W-1:0] vec[10];
		vec = '{32'd0, 32'd1, 32'd3, 32'd7, 32'd27, 32'd31, 32'd255,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		foreach (vec[i])
			send_residue(vec[i], rand_gap());
		drain();
	endtask

	// depth 0 reads as 1, values above the cell count saturate
	task automatic test_depth_extremes();
		logic [LVL_W-1:0] depths[4];
		logic [RES_W-1:0] vec[4];
		depths = '{6'd0, 6'd1, 6'd32, 6'd63};
		vec    = '{32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF};
		foreach (depths[d]) begin
			write_depth(depths[d]);
			foreach (vec[i])
				send_residue(vec[i], rand_gap());
			drain();
		end
	endtask

	task automatic test_random_sweep();
		logic [LVL_W-1:0] depths[12];
		depths = '{6'd2, 6'd3, 6'd5, 6'd8, 6'd11, 6'd16, 6'd20, 6'd24,
			6'd30, 6'd31, 6'd32, 6'd33};
		foreach (depths[p]) begin
			write_depth((p == 11) ? LVL_W'($urandom_range(33, 63)) : depths[p]);
			tx_steady = (p % 3 == 1);
			rx_steady = (p % 4 == 2);
			for (int i = 0; i < 40; i++)
				send_residue(pick_residue(), tx_steady ? 0 : rand_gap());
			drain();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver holds off long enough for the row and skid slot to fill
	task automatic test_backpressure();
		write_depth(6'd32);
		@(negedge clk);
		hold_cycles = 200;
		for (int i = 0; i < 80; i++)
			send_residue(pick_residue(), 0);
		drain();
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		depth_reg = LVL_W'(SIEVE_DEPTH_RESET);
		mismatches     = 0;
		errors         = 0;
		n_sent         = 0;
		n_live         = 0;
		n_dead         = 0;
		n_in_stalls    = 0;
		n_depth_writes = 0;
		hold_cycles    = 0;
		tx_steady      = 1'b0;
		rx_steady      = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_depth();
		test_depth_extremes();
		test_random_sweep();
		test_backpressure();

		if (verdict_q.size() != 0) begin
			$display("%0d requests never got a result", verdict_q.size());
			errors++;
		end
		$display("%0d residues over %0d depth writes: %0d live, %0d dead, %0d input stalls",
			n_sent, n_depth_writes, n_live, n_dead, n_in_stalls);
		$display("%0d mismatches, %0d other errors", mismatches, errors);
		if (mismatches == 0 && errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		rx_gap   = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (rx_steady) begin
				m_tready <= 1'b1;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else begin
				m_tready <= 1'b1;
				rx_gap = rand_gap();
			end
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (s_tvalid && !s_tready && arst_n)
			n_in_stalls++;
		if (m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				errors++;
				$display("unexpected result live=%0b at %0t", m_tdata[0], $realtime);
			end else begin
				v = verdict_q.pop_front();
				if (v.live)
					n_live++;
				else
					n_dead++;
				if (m_tdata[0] !== v.live) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: residue %h depth %0d live exp %0b got %0b",
							v.residue, v.depth, v.live, m_tdata[0]);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("tb: failure");
		$finish;
	end

endmodule
